[hw/rtl/ceta_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ceta_pkg: shared types and constants
// Register indexes, divider handshake structs, calendar constants and the
// month length / leap year helpers for the calendar elapsed time adder.
// ---------------------------------------------------------------------------
package ceta_pkg;

    // Field widths
    localparam int unsigned TickW   = 32;
    localparam int unsigned YearW   = 12;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned SecondW = 6;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    // Divider widths: divisors are at most 1000
    localparam int unsigned DivW  = 32;
    localparam int unsigned DvsW  = 10;
    localparam int unsigned MagW  = 32;
    localparam int unsigned ProdW = DivW + MagW;

    // Running day count before the month walk (base day plus about 50 days)
    localparam int unsigned DayAccW = 8;

    // Divisors
    localparam logic [DvsW-1:0] MsPerSec     = DvsW'(1000);
    localparam logic [DvsW-1:0] SecPerMin    = DvsW'(60);
    localparam logic [DvsW-1:0] MinPerHour   = DvsW'(60);
    localparam logic [DvsW-1:0] HourPerDay   = DvsW'(24);

    // Reciprocals: q = (x * mag) >> shift is exact for every 32-bit x
    localparam logic [MagW-1:0] MsPerSecMag   = 32'd274877907;
    localparam int unsigned     MsPerSecShift = 38;
    localparam logic [MagW-1:0] SixtyMag      = 32'd2290649225;
    localparam int unsigned     SixtyShift    = 37;
    localparam logic [MagW-1:0] DayMag        = 32'd2863311531;
    localparam int unsigned     DayShift      = 36;

    localparam logic [TickW-1:0] ElapsedLimit = TickW'(100000000);

    // Accepted base range
    localparam logic [YearW-1:0] YearMin = YearW'(2023);
    localparam logic [YearW-1:0] YearMax = YearW'(2100);
    localparam logic [YearW-1:0] CenturyNoLeap = YearW'(2100);

    // Fallback time 2023-01-01 12:00:00
    localparam logic [YearW-1:0]   FbYear   = YearW'(2023);
    localparam logic [MonthW-1:0]  FbMonth  = MonthW'(1);
    localparam logic [DayW-1:0]    FbDay    = DayW'(1);
    localparam logic [HourW-1:0]   FbHour   = HourW'(12);
    localparam logic [MinuteW-1:0] FbMinute = MinuteW'(0);
    localparam logic [SecondW-1:0] FbSecond = SecondW'(0);

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_BASE_YEAR   = 3'd0,
        CFG_BASE_MONTH  = 3'd1,
        CFG_BASE_DAY    = 3'd2,
        CFG_BASE_HOUR   = 3'd3,
        CFG_BASE_MINUTE = 3'd4,
        CFG_BASE_SECOND = 3'd5,
        CFG_BASE_TICK   = 3'd6,
        CFG_TIME_VALID  = 3'd7
    } cfg_idx_t;

    // Stored base time
    typedef struct packed {
        logic [YearW-1:0]   base_year;
        logic [MonthW-1:0]  base_month;
        logic [DayW-1:0]    base_day;
        logic [HourW-1:0]   base_hour;
        logic [MinuteW-1:0] base_minute;
        logic [SecondW-1:0] base_second;
        logic [TickW-1:0]   base_tick;
        logic               time_valid;
    } cfg_t;

    // Divider request and response
    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [DvsW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quotient;
        logic [DvsW-1:0] remainder;
    } div_rsp_t;

    // Leap rule; years seen by the month walk stay within 2023..2103, where
    // 2100 is the only century year
    function automatic logic is_leap(input logic [YearW-1:0] y);
        return (y[1:0] == 2'b00) && (y != CenturyNoLeap);
    endfunction

    // Days in a month; codes outside 1..12 count as 31 days
    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                   input logic leap);
        logic [DayW-1:0] len;
        case (m)
            4'd1:    len = DayW'(31);
            4'd2:    len = leap ? DayW'(29) : DayW'(28);
            4'd3:    len = DayW'(31);
            4'd4:    len = DayW'(30);
            4'd5:    len = DayW'(31);
            4'd6:    len = DayW'(30);
            4'd7:    len = DayW'(31);
            4'd8:    len = DayW'(31);
            4'd9:    len = DayW'(30);
            4'd10:   len = DayW'(31);
            4'd11:   len = DayW'(30);
            4'd12:   len = DayW'(31);
            default: len = DayW'(31);
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ceta_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ceta_if: channel interfaces
// Tick request channel and calendar time result channel, valid/ready.
// ---------------------------------------------------------------------------

// Tick request channel
interface ceta_tick_if
    import ceta_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [TickW-1:0] current_tick;

    modport source (output valid, output current_tick, input ready);
    modport sink   (input valid, input current_tick, output ready);
endinterface

// Calendar time result channel
interface ceta_time_if
    import ceta_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic               is_fallback;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second, output is_fallback, input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second, input is_fallback, output ready);
endinterface
`default_nettype wire

[hw/rtl/calendar_elapsed_time_adder_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// calendar_elapsed_time_adder_unit: tick count to calendar date and time
// Sequence: four divides in the shared reciprocal divider (ms, s, min, h), then
//   a month walk, one step per month crossed (at most two) plus a final step,
//   then the output load; a fallback result skips the month walk.
// Throughput: one word in flight; the next word is accepted the cycle after the
//   result loads, and a stalled result holds the sequencer until it is taken.
// Reset: base time 2023-01-01 00:00:00, tick 0, not valid; sequencer idle,
//   no result pending.
// ---------------------------------------------------------------------------
module calendar_elapsed_time_adder_unit
    import ceta_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    ceta_tick_if.sink                tick,
    ceta_time_if.source              cal
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DIV_MS   = 7'b0000010,
        ST_DIV_SEC  = 7'b0000100,
        ST_DIV_MIN  = 7'b0001000,
        ST_DIV_HOUR = 7'b0010000,
        ST_WALK     = 7'b0100000,
        ST_FINISH   = 7'b1000000
    } state_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t               state_reg, state_next;
    logic                 elapsed_ok_reg, elapsed_ok_next;
    logic                 ok_reg, ok_next;
    logic [SecondW-1:0]   sec_reg, sec_next;
    logic [MinuteW-1:0]   min_reg, min_next;
    logic [HourW-1:0]     hour_reg, hour_next;
    logic [DayAccW-1:0]   day_reg, day_next;
    logic [MonthW-1:0]    mon_reg, mon_next;
    logic [YearW-1:0]     year_reg, year_next;

    logic                 out_valid_reg, out_valid_next;
    logic [YearW-1:0]     year_out_reg, year_out_next;
    logic [MonthW-1:0]    mon_out_reg, mon_out_next;
    logic [DayW-1:0]      day_out_reg, day_out_next;
    logic [HourW-1:0]     hour_out_reg, hour_out_next;
    logic [MinuteW-1:0]   min_out_reg, min_out_next;
    logic [SecondW-1:0]   sec_out_reg, sec_out_next;
    logic                 fb_out_reg, fb_out_next;

    logic                 base_ok;
    logic [DayW-1:0]      mon_len;

    ceta_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ceta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Base registers set and in range
    assign base_ok = cfg.time_valid && (cfg.base_tick != '0)
        && (cfg.base_year >= YearMin) && (cfg.base_year <= YearMax)
        && (cfg.base_month >= MonthW'(1)) && (cfg.base_month <= MonthW'(12))
        && (cfg.base_day != '0) && (cfg.base_hour <= HourW'(23))
        && (cfg.base_minute <= MinuteW'(59)) && (cfg.base_second <= SecondW'(59));

    assign mon_len = month_days(mon_reg, is_leap(year_reg));

    // Sequencer: divide chain, month walk, output load
    always_comb
    begin
        state_next      = state_reg;
        elapsed_ok_next = elapsed_ok_reg;
        ok_next         = ok_reg;
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        mon_next        = mon_reg;
        year_next       = year_reg;
        out_valid_next  = out_valid_reg;
        year_out_next   = year_out_reg;
        mon_out_next    = mon_out_reg;
        day_out_next    = day_out_reg;
        hour_out_next   = hour_out_reg;
        min_out_next    = min_out_reg;
        sec_out_next    = sec_out_reg;
        fb_out_next     = fb_out_reg;
        div_req         = '0;

        // Result word taken
        if (cal.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tick.valid)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = tick.current_tick - cfg.base_tick;
                    div_req.divisor  = MsPerSec;
                    state_next       = ST_DIV_MS;
                end
            end
            ST_DIV_MS:
            begin
                if (div_rsp.done)
                begin
                    elapsed_ok_next  = div_rsp.quotient < ElapsedLimit;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient + DivW'(cfg.base_second);
                    div_req.divisor  = SecPerMin;
                    state_next       = ST_DIV_SEC;
                end
            end
            ST_DIV_SEC:
            begin
                if (div_rsp.done)
                begin
                    sec_next         = div_rsp.remainder[SecondW-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient + DivW'(cfg.base_minute);
                    div_req.divisor  = MinPerHour;
                    state_next       = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                if (div_rsp.done)
                begin
                    min_next         = div_rsp.remainder[MinuteW-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient + DivW'(cfg.base_hour);
                    div_req.divisor  = HourPerDay;
                    state_next       = ST_DIV_HOUR;
                end
            end
            ST_DIV_HOUR:
            begin
                if (div_rsp.done)
                begin
                    // whole days stay far below 2^8 for any 32-bit tick span
                    hour_next  = div_rsp.remainder[HourW-1:0];
                    day_next   = div_rsp.quotient[DayAccW-1:0] + DayAccW'(cfg.base_day);
                    mon_next   = cfg.base_month;
                    year_next  = cfg.base_year;
                    ok_next    = base_ok && elapsed_ok_reg;
                    state_next = (base_ok && elapsed_ok_reg) ? ST_WALK : ST_FINISH;
                end
            end
            ST_WALK:
            begin
                // one month per cycle until the day fits
                if (day_reg <= DayAccW'(mon_len))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    day_next = day_reg - DayAccW'(mon_len);
                    if (mon_reg == MonthW'(12))
                    begin
                        mon_next  = MonthW'(1);
                        year_next = year_reg + YearW'(1);
                    end
                    else
                    begin
                        mon_next = mon_reg + MonthW'(1);
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || cal.ready)
                begin
                    out_valid_next = 1'b1;
                    fb_out_next    = !ok_reg;
                    if (ok_reg)
                    begin
                        year_out_next = year_reg;
                        mon_out_next  = mon_reg;
                        day_out_next  = day_reg[DayW-1:0];
                        hour_out_next = hour_reg;
                        min_out_next  = min_reg;
                        sec_out_next  = sec_reg;
                    end
                    else
                    begin
                        year_out_next = FbYear;
                        mon_out_next  = FbMonth;
                        day_out_next  = FbDay;
                        hour_out_next = FbHour;
                        min_out_next  = FbMinute;
                        sec_out_next  = FbSecond;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and output datapath
    always_ff @(posedge clk)
    begin
        elapsed_ok_reg <= elapsed_ok_next;
        ok_reg         <= ok_next;
        sec_reg        <= sec_next;
        min_reg        <= min_next;
        hour_reg       <= hour_next;
        day_reg        <= day_next;
        mon_reg        <= mon_next;
        year_reg       <= year_next;
        year_out_reg   <= year_out_next;
        mon_out_reg    <= mon_out_next;
        day_out_reg    <= day_out_next;
        hour_out_reg   <= hour_out_next;
        min_out_reg    <= min_out_next;
        sec_out_reg    <= sec_out_next;
        fb_out_reg     <= fb_out_next;
    end

    assign tick.ready      = (state_reg == ST_IDLE);
    assign cal.valid       = out_valid_reg;
    assign cal.year        = year_out_reg;
    assign cal.month       = mon_out_reg;
    assign cal.day         = day_out_reg;
    assign cal.hour        = hour_out_reg;
    assign cal.minute      = min_out_reg;
    assign cal.second      = sec_out_reg;
    assign cal.is_fallback = fb_out_reg;

endmodule
`default_nettype wire

[hw/rtl/ceta_cfg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ceta_cfg: base time register file
// Decodes configuration writes and holds the stored base date, time and tick.
// ---------------------------------------------------------------------------
module ceta_cfg
    import ceta_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Write decode; each register keeps the low bits of the data word
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE_YEAR:   cfg_next.base_year   = cfg_data[YearW-1:0];
                CFG_BASE_MONTH:  cfg_next.base_month  = cfg_data[MonthW-1:0];
                CFG_BASE_DAY:    cfg_next.base_day    = cfg_data[DayW-1:0];
                CFG_BASE_HOUR:   cfg_next.base_hour   = cfg_data[HourW-1:0];
                CFG_BASE_MINUTE: cfg_next.base_minute = cfg_data[MinuteW-1:0];
                CFG_BASE_SECOND: cfg_next.base_second = cfg_data[SecondW-1:0];
                CFG_BASE_TICK:   cfg_next.base_tick   = cfg_data[TickW-1:0];
                CFG_TIME_VALID:  cfg_next.time_valid  = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_year   <= FbYear;
            cfg_reg.base_month  <= MonthW'(1);
            cfg_reg.base_day    <= DayW'(1);
            cfg_reg.base_hour   <= '0;
            cfg_reg.base_minute <= '0;
            cfg_reg.base_second <= '0;
            cfg_reg.base_tick   <= '0;
            cfg_reg.time_valid  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[hw/rtl/ceta_div.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// ceta_div: shared constant divider
// Unsigned 32-bit division by 1000, 60 or 24 through a reciprocal multiply:
// operand load, 32 x 32 product, quotient, remainder; done rises with the remainder.
// ---------------------------------------------------------------------------
module ceta_div
    import ceta_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              ph1_reg, ph1_next;
    logic              ph2_reg, ph2_next;
    logic              ph3_reg, ph3_next;
    logic              done_reg, done_next;
    logic [DivW-1:0]   num_reg, num_next;
    logic [MagW-1:0]   mag_reg, mag_next;
    logic [DvsW-1:0]   dvs_reg, dvs_next;
    logic [ProdW-1:0]  prod_reg, prod_next;
    logic [DivW-1:0]   quo_reg, quo_next;
    logic [DvsW-1:0]   rem_reg, rem_next;
    logic [MagW-1:0]   mag_sel;

    // Reciprocal for the requested divisor
    always_comb
    begin
        case (req.divisor)
            MsPerSec:   mag_sel = MsPerSecMag;
            SecPerMin:  mag_sel = SixtyMag;
            HourPerDay: mag_sel = DayMag;
            default:    mag_sel = '0;
        endcase
    end

    // Operand load, product, quotient, remainder
    always_comb
    begin
        ph1_next  = 1'b0;
        ph2_next  = ph1_reg;
        ph3_next  = ph2_reg;
        done_next = ph3_reg;
        num_next  = num_reg;
        mag_next  = mag_reg;
        dvs_next  = dvs_reg;
        prod_next = prod_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;

        if (req.start)
        begin
            ph1_next = 1'b1;
            num_next = req.dividend;
            mag_next = mag_sel;
            dvs_next = req.divisor;
        end

        if (ph1_reg)
        begin
            prod_next = ProdW'(num_reg) * ProdW'(mag_reg);
        end

        if (ph2_reg)
        begin
            case (dvs_reg)
                MsPerSec:   quo_next = DivW'(prod_reg >> MsPerSecShift);
                SecPerMin:  quo_next = DivW'(prod_reg >> SixtyShift);
                HourPerDay: quo_next = DivW'(prod_reg >> DayShift);
                default:    quo_next = '0;
            endcase
        end

        if (ph3_reg)
        begin
            // remainder is below 1000, so the low ten bits of x - q*d are exact
            rem_next = num_reg[DvsW-1:0] - DvsW'(quo_reg[DvsW-1:0] * dvs_reg);
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            ph3_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ph1_reg  <= ph1_next;
            ph2_reg  <= ph2_next;
            ph3_reg  <= ph3_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        mag_reg  <= mag_next;
        dvs_reg  <= dvs_next;
        prod_reg <= prod_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

[sim/tb_calendar_elapsed_time_adder_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tb_calendar_elapsed_time_adder_unit: self-checking bench for the tick to
// calendar time unit
// Loads a series of base times through the register port and sends tick
// words. Each word is predicted in the bench (elapsed seconds, carries, and
// a Gregorian month walk) and checked field by field against the result
// channel. Both channels idle and stall in random bursts.
// ---------------------------------------------------------------------------
module tb_calendar_elapsed_time_adder_unit;
    import ceta_pkg::*;

    localparam int unsigned CycleLimit = 600000;
    localparam int unsigned TailCycles = 150;

    // Base time as the bench believes the block holds it
    typedef struct packed {
        logic [YearW-1:0]   yr;
        logic [MonthW-1:0]  mon;
        logic [DayW-1:0]    dd;
        logic [HourW-1:0]   hh;
        logic [MinuteW-1:0] mm;
        logic [SecondW-1:0] ss;
        logic [TickW-1:0]   tick;
        logic               known;
    } stamp_t;

    // One calendar result word
    typedef struct packed {
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
        logic               is_fallback;
    } cal_word_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    ceta_tick_if tick_ch ();
    ceta_time_if cal_ch ();

    calendar_elapsed_time_adder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_ch),
        .cal       (cal_ch)
    );

    stamp_t                 base;
    logic [TickW-1:0]       tick_backlog[$];
    cal_word_t              due_times[$];
    bit                     quiet;
    int unsigned            send_gap;
    int unsigned            hold_gap;
    int unsigned            fail_count;
    int unsigned            words_checked;
    int unsigned            fallback_seen;
    int unsigned            settings_used;
    int unsigned            cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Days in a month, Gregorian leap rule
    function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
        if (m == 2)
            return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // Calendar time for a tick count, given the stored base
    function automatic cal_word_t calendar_at(input stamp_t b, input logic [TickW-1:0] now);
        cal_word_t        w;
        logic [TickW-1:0] span;
        int unsigned      secs;
        int unsigned      s;
        int unsigned      mi;
        int unsigned      h;
        int unsigned      d;
        int unsigned      mo;
        int unsigned      y;
        bit               ok;
        span = now - b.tick;
        secs = span / MsPerSec;
        ok = b.known && (b.tick != 0) && (secs < ElapsedLimit)
            && (b.yr >= YearMin) && (b.yr <= YearMax)
            && (b.mon >= 1) && (b.mon <= 12) && (b.dd >= 1)
            && (b.hh <= 23) && (b.mm <= 59) && (b.ss <= 59);
        w = '{FbYear, FbMonth, FbDay, FbHour, FbMinute, FbSecond, 1'b1};
        if (ok)
        begin
            s = b.ss + secs;
            mi = b.mm + s / 60;
            s = s % 60;
            h = b.hh + mi / 60;
            mi = mi % 60;
            d = b.dd + h / 24;
            h = h % 24;
            y = b.yr;
            mo = b.mon;
            // walk months; December rolls into the next year
            while (d > month_len(mo, y))
            begin
                d = d - month_len(mo, y);
                mo = mo + 1;
                if (mo > 12)
                begin
                    mo = 1;
                    y = y + 1;
                end
            end
            w = '{YearW'(y), MonthW'(mo), DayW'(d), HourW'(h), MinuteW'(mi),
                  SecondW'(s), 1'b0};
        end
        return w;
    endfunction

    task automatic flag(input string what);
        if (fail_count < 50)
            $display("MISMATCH: %s", what);
        fail_count++;
    endtask

    // Compare one result word against the oldest prediction
    task automatic check_word(input cal_word_t got);
        cal_word_t want;
        if (due_times.size() == 0)
        begin
            flag($sformatf("result %04d-%02d-%02d %02d:%02d:%02d with nothing expected",
                           got.year, got.month, got.day, got.hour, got.minute, got.second));
            return;
        end
        want = due_times.pop_front();
        if (got.year !== want.year)
            flag($sformatf("word %0d year %0d, want %0d", words_checked, got.year, want.year));
        if (got.month !== want.month)
            flag($sformatf("word %0d month %0d, want %0d", words_checked, got.month,
                           want.month));
        if (got.day !== want.day)
            flag($sformatf("word %0d day %0d, want %0d", words_checked, got.day, want.day));
        if (got.hour !== want.hour)
            flag($sformatf("word %0d hour %0d, want %0d", words_checked, got.hour, want.hour));
        if (got.minute !== want.minute)
            flag($sformatf("word %0d minute %0d, want %0d", words_checked, got.minute,
                           want.minute));
        if (got.second !== want.second)
            flag($sformatf("word %0d second %0d, want %0d", words_checked, got.second,
                           want.second));
        if (got.is_fallback !== want.is_fallback)
            flag($sformatf("word %0d fallback flag %0d, want %0d", words_checked,
                           got.is_fallback, want.is_fallback));
        if (want.is_fallback)
            fallback_seen++;
        words_checked++;
    endtask

    // Mirror of the base registers, updated on each register write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base <= '{YearMin, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd0, 1'b0};
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_YEAR:   base.yr <= cfg_data[YearW-1:0];
                CFG_BASE_MONTH:  base.mon <= cfg_data[MonthW-1:0];
                CFG_BASE_DAY:    base.dd <= cfg_data[DayW-1:0];
                CFG_BASE_HOUR:   base.hh <= cfg_data[HourW-1:0];
                CFG_BASE_MINUTE: base.mm <= cfg_data[MinuteW-1:0];
                CFG_BASE_SECOND: base.ss <= cfg_data[SecondW-1:0];
                CFG_BASE_TICK:   base.tick <= cfg_data[TickW-1:0];
                CFG_TIME_VALID:  base.known <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Tick driver: predicts each accepted word, idles in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_ch.valid <= 1'b0;
            tick_ch.current_tick <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
                due_times.push_back(calendar_at(base, tick_ch.current_tick));
            if (!(tick_ch.valid && !tick_ch.ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    tick_ch.valid <= 1'b0;
                end
                else if (!quiet && tick_backlog.size() != 0 && $urandom_range(0, 9) == 0)
                begin
                    send_gap <= $urandom_range(0, 5);
                    tick_ch.valid <= 1'b0;
                end
                else if (tick_backlog.size() != 0)
                begin
                    tick_ch.valid <= 1'b1;
                    tick_ch.current_tick <= tick_backlog.pop_front();
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted word, stalls in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_ch.ready <= 1'b0;
            hold_gap <= 0;
        end
        else
        begin
            if (cal_ch.valid && cal_ch.ready)
                check_word('{cal_ch.year, cal_ch.month, cal_ch.day, cal_ch.hour,
                             cal_ch.minute, cal_ch.second, cal_ch.is_fallback});
            if (hold_gap != 0)
            begin
                hold_gap <= hold_gap - 1;
                cal_ch.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                hold_gap <= $urandom_range(0, 5);
                cal_ch.ready <= 1'b0;
            end
            else
                cal_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit)
        begin
            $display("Timeout after %0d cycles, %0d words still due", cycles, due_times.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Wait until no word is queued, in flight, or due
    task automatic drain();
        do
            @(negedge clk);
        while (tick_backlog.size() != 0 || tick_ch.valid || due_times.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // One register write; bits above the register width carry junk
    task automatic write_reg(input cfg_idx_t idx, input int unsigned w,
                             input logic [CfgDataW-1:0] value);
        logic [CfgDataW-1:0] junk;
        junk = $urandom;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= (w >= CfgDataW) ? value : ((junk << w) | value);
    endtask

    task automatic load_base(input stamp_t s, input bit tick_only);
        drain();
        if (!tick_only)
        begin
            write_reg(CFG_BASE_YEAR, YearW, s.yr);
            write_reg(CFG_BASE_MONTH, MonthW, s.mon);
            write_reg(CFG_BASE_DAY, DayW, s.dd);
            write_reg(CFG_BASE_HOUR, HourW, s.hh);
            write_reg(CFG_BASE_MINUTE, MinuteW, s.mm);
            write_reg(CFG_BASE_SECOND, SecondW, s.ss);
            write_reg(CFG_TIME_VALID, 1, s.known);
        end
        write_reg(CFG_BASE_TICK, TickW, s.tick);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Random base: mostly well formed, some out of range or unset
    function automatic stamp_t random_base();
        stamp_t s;
        s.yr = $urandom_range(YearMin, YearMax);
        s.mon = $urandom_range(1, 12);
        s.dd = $urandom_range(1, 31);
        s.hh = $urandom_range(0, 23);
        s.mm = $urandom_range(0, 59);
        s.ss = $urandom_range(0, 59);
        s.tick = $urandom;
        if (s.tick == 0)
            s.tick = 1;
        s.known = 1'b1;
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                case ($urandom_range(0, 5))
                    0: s.yr = $urandom_range(0, 1) ? $urandom_range(0, YearMin - 1)
                                                   : $urandom_range(YearMax + 1, 4095);
                    1: s.mon = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(13, 15);
                    2: s.dd = 0;
                    3: s.hh = $urandom_range(24, 31);
                    4: s.mm = $urandom_range(60, 63);
                    default: s.ss = $urandom_range(60, 63);
                endcase
            end
            3: s.known = 1'b0;
            4: s.tick = 0;
            default: ;
        endcase
        return s;
    endfunction

    // Tick near the base: short spans, whole days, or anywhere
    function automatic logic [TickW-1:0] random_tick(input stamp_t s);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return s.tick + $urandom_range(0, 200000);
            4, 5, 6:    return s.tick + $urandom_range(0, 49) * 32'd86400000
                               + $urandom_range(0, 2000) - 32'd1000;
            default:    return $urandom;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        stamp_t      plan;
        stamp_t      bad[10];
        int unsigned n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BASE_YEAR;
        cfg_data = '0;
        tick_ch.valid = 1'b0;
        tick_ch.current_tick = '0;
        cal_ch.ready = 1'b0;
        quiet = 1'b0;
        fail_count = 0;
        words_checked = 0;
        fallback_seen = 0;
        settings_used = 0;
        cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // base left unset after reset
        tick_backlog.push_back(32'd0);
        tick_backlog.push_back(32'hFFFF_FFFF);

        // earliest base, smallest nonzero tick; includes the longest wrap
        plan = '{12'd2023, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'd1, 1'b1};
        load_base(plan, 1'b0);
        tick_backlog.push_back(32'd1);
        tick_backlog.push_back(32'd1000);
        tick_backlog.push_back(32'd1001);
        tick_backlog.push_back(32'd0);
        tick_backlog.push_back(32'd86400001);
        tick_backlog.push_back(32'hAAAA_AAAA);
        tick_backlog.push_back(32'h5555_5555);

        // leap day, with base tick at the top of the range
        plan = '{12'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 32'hFFFF_FFFF, 1'b1};
        load_base(plan, 1'b0);
        tick_backlog.push_back(32'd999);
        tick_backlog.push_back(32'd86400999);

        // century year without a leap day
        plan = '{12'd2100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 32'h1234_5678, 1'b1};
        load_base(plan, 1'b0);
        tick_backlog.push_back(32'h1234_5678 + 32'd1000);

        // last base day: rolls into the next year
        plan = '{12'd2100, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 32'd1, 1'b1};
        load_base(plan, 1'b0);
        tick_backlog.push_back(32'd1001);
        tick_backlog.push_back(32'd0);

        // base day past the month end
        plan = '{12'd2023, 4'd4, 5'd31, 5'd12, 6'd0, 6'd0, 32'd5, 1'b1};
        load_base(plan, 1'b0);
        tick_backlog.push_back(32'd5);

        // invalid bases, each gives the fallback time
        plan = '{12'd2050, 4'd6, 5'd15, 5'd10, 6'd30, 6'd30, 32'd777, 1'b1};
        foreach (bad[i])
            bad[i] = plan;
        bad[0].yr = 12'd2022;
        bad[1].yr = 12'd4095;
        bad[2].mon = 4'd0;
        bad[3].mon = 4'd13;
        bad[4].dd = 5'd0;
        bad[5].hh = 5'd24;
        bad[6].mm = 6'd60;
        bad[7].ss = 6'd63;
        bad[8].known = 1'b0;
        bad[9].tick = 32'd0;
        foreach (bad[i])
        begin
            load_base(bad[i], 1'b0);
            tick_backlog.push_back(32'd5000);
        end

        // random bases and ticks; the last phases run without idling
        for (int p = 0; p < 26; p++)
        begin
            if (p >= 22)
                quiet = 1'b1;
            if (p > 0 && $urandom_range(0, 3) == 0)
            begin
                plan.tick = $urandom;
                load_base(plan, 1'b1);
            end
            else
            begin
                plan = random_base();
                load_base(plan, 1'b0);
            end
            n = 25;
            // a burst of words for this base
            for (int k = 0; k < n; k++)
                tick_backlog.push_back(random_tick(plan));
        end

        drain();
        repeat (TailCycles) @(posedge clk);
        if (due_times.size() != 0)
            flag($sformatf("%0d words never came back", due_times.size()));

        $display("Checked %0d calendar words across %0d base settings (%0d fallback).",
                 words_checked, settings_used, fallback_seen);
        $display("Leap days, century year, year rollover, invalid bases and tick wrap covered.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

[calendar_elapsed_time_adder_unit.f]
hw/rtl/ceta_pkg.sv
hw/rtl/ceta_if.sv
hw/rtl/ceta_cfg.sv
hw/rtl/ceta_div.sv
hw/rtl/calendar_elapsed_time_adder_unit.sv
sim/tb_calendar_elapsed_time_adder_unit.sv
